// File: design/fme_pkg.sv
// ----------------------------------------------------------------------------
// Fuzzy membership evaluator package
// Register indexes and shape codes shared by the fuzzifier modules.
// ----------------------------------------------------------------------------
package fme_pkg;

    localparam logic [2:0] REG_SHAPE   = 3'd0;
    localparam logic [2:0] REG_POINT_A = 3'd1;
    localparam logic [2:0] REG_POINT_B = 3'd2;
    localparam logic [2:0] REG_POINT_C = 3'd3;
    localparam logic [2:0] REG_POINT_D = 3'd4;

    localparam logic [2:0] SHAPE_TRI   = 3'd0;
    localparam logic [2:0] SHAPE_TRAP  = 3'd1;
    localparam logic [2:0] SHAPE_S     = 3'd2;
    localparam logic [2:0] SHAPE_Z     = 3'd3;
    localparam logic [2:0] SHAPE_PI    = 3'd4;

    // How a curve finishes once its fractional term is known.
    localparam logic [1:0] FIN_ZERO = 2'd0;
    localparam logic [1:0] FIN_ONE  = 2'd1;
    localparam logic [1:0] FIN_TERM = 2'd2;
    localparam logic [1:0] FIN_INV  = 2'd3;

endpackage

// File: design/fuzzy_membership_eval.sv
// ----------------------------------------------------------------------------
// Fuzzy membership evaluator
// Maps each sample to a membership degree under a configured shape.
// ----------------------------------------------------------------------------
// The block accepts one sample per cycle while it is not stalled and returns
// one degree per sample, in order. The pipeline holds two front stages for
// branch decisions and squares, one divider stage per quotient bit plus one
// setup stage, a finishing stage, the Pi product stage and the output
// register. The whole pipeline advances when the output register is free or
// being read, so back pressure stalls it without losing any beat.
module fuzzy_membership_eval #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int DEGREE_FRAC_BITS = 15
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [SAMPLE_WIDTH-1:0]    s_sample,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [DEGREE_FRAC_BITS:0]  m_degree,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [2:0]                 cfg_index,
    input  logic [SAMPLE_WIDTH-1:0]    cfg_data
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int F = DEGREE_FRAC_BITS;
    localparam int NW = 2 * SW + 3;
    localparam int LAT = F + 5;

    logic [2:0]    shape_reg;
    logic [SW-1:0] pa_reg, pb_reg, pc_reg, pd_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shape_reg <= '0;
            pa_reg <= '0;
            pb_reg <= '0;
            pc_reg <= '0;
            pd_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                fme_pkg::REG_SHAPE:   shape_reg <= cfg_data[2:0];
                fme_pkg::REG_POINT_A: pa_reg <= cfg_data;
                fme_pkg::REG_POINT_B: pb_reg <= cfg_data;
                fme_pkg::REG_POINT_C: pc_reg <= cfg_data;
                fme_pkg::REG_POINT_D: pd_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    logic [LAT-1:0] vld_reg;
    logic out_valid_reg;
    logic [F:0] out_reg;

    assign en = !out_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
            out_valid_reg <= vld_reg[LAT-1];
        end
    end

    logic [NW-1:0] num0, den0, num1, den1;
    logic [1:0]    fin0, fin1;
    logic          use_pi;

    fme_front #(.SW(SW)) u_front (
        .aclk(aclk), .en(en), .shape(shape_reg), .x_in(s_sample),
        .pa(pa_reg), .pb(pb_reg), .pc(pc_reg), .pd(pd_reg),
        .num0(num0), .den0(den0), .num1(num1), .den1(den1),
        .fin0(fin0), .fin1(fin1), .use_pi(use_pi)
    );

    logic [F:0] q0, q1;
    logic [4:0] t0, t1;

    fme_ratio #(.NW(NW), .FRAC(F), .TW(5)) u_div0 (
        .aclk(aclk), .en(en), .num(num0), .den(den0),
        .tag_in({use_pi, fin1, fin0}), .quo(q0), .tag_out(t0)
    );

    fme_ratio #(.NW(NW), .FRAC(F), .TW(5)) u_div1 (
        .aclk(aclk), .en(en), .num(num1), .den(den1),
        .tag_in('0), .quo(q1), .tag_out(t1)
    );

    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    function automatic logic [F:0] finish(logic [1:0] fin, logic [F:0] q);
        logic [F:0] r;
        r = '0;
        case (fin)
            fme_pkg::FIN_ZERO: r = '0;
            fme_pkg::FIN_ONE:  r = ONE;
            fme_pkg::FIN_TERM: r = q;
            fme_pkg::FIN_INV:  r = ONE - q;
            default:           r = '0;
        endcase
        return r;
    endfunction

    logic [F:0] s_reg, z_reg, deg_reg;
    logic       pi_reg;
    logic [2*F+1:0] prod;

    assign prod = s_reg * z_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg   <= finish(t0[1:0], q0);
            z_reg   <= finish(t0[3:2], q1);
            pi_reg  <= t0[4] | (t1 != t1);
            deg_reg <= pi_reg ? prod[2*F:F] : s_reg;
            out_reg <= deg_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_degree = out_reg;

endmodule

// File: design/fme_ratio.sv
// ----------------------------------------------------------------------------
// Pipelined fraction divider
// Computes floor(num * 2^FRAC / den) saturated at 1.0, one quotient bit per
// pipeline stage, accepting one operand pair per cycle with a shared enable.
// Zero divisor gives 1.0. A tag travels alongside the operands.
// ----------------------------------------------------------------------------
module fme_ratio #(
    parameter int NW = 32,
    parameter int FRAC = 15,
    parameter int TW = 8
) (
    input  logic            aclk,
    input  logic            en,
    input  logic [NW-1:0]   num,
    input  logic [NW-1:0]   den,
    input  logic [TW-1:0]   tag_in,
    output logic [FRAC:0]   quo,
    output logic [TW-1:0]   tag_out
);

    logic [NW:0]   rem_reg [FRAC+1];
    logic [NW-1:0] den_reg [FRAC+1];
    logic [FRAC:0] q_reg   [FRAC+1];
    logic          sat_reg [FRAC+1];
    logic [TW-1:0] tag_reg [FRAC+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= {1'b0, num};
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            sat_reg[0] <= (den == '0) || (num >= den);
            tag_reg[0] <= tag_in;
        end
    end

    for (genvar i = 0; i < FRAC; i++) begin : g_step
        logic [NW+1:0] sh;
        logic          ge;
        assign sh = {rem_reg[i], 1'b0};
        assign ge = sh >= {2'b0, den_reg[i]};
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i+1] <= ge ? (NW+1)'(sh - {2'b0, den_reg[i]}) : sh[NW:0];
                den_reg[i+1] <= den_reg[i];
                q_reg[i+1]   <= {q_reg[i][FRAC-1:0], ge};
                sat_reg[i+1] <= sat_reg[i];
                tag_reg[i+1] <= tag_reg[i];
            end
        end
    end

    assign quo = sat_reg[FRAC] ? {1'b1, {FRAC{1'b0}}} : q_reg[FRAC];
    assign tag_out = tag_reg[FRAC];

endmodule

// File: design/fme_front.sv
// ----------------------------------------------------------------------------
// Fuzzy membership front end
// Two register stages: branch decisions and differences, then the squares
// that feed the S and Z quadratic terms.
// ----------------------------------------------------------------------------
module fme_front #(
    parameter int SW = 16
) (
    input  logic            aclk,
    input  logic            en,
    input  logic [2:0]      shape,
    input  logic [SW-1:0]   x_in,
    input  logic [SW-1:0]   pa,
    input  logic [SW-1:0]   pb,
    input  logic [SW-1:0]   pc,
    input  logic [SW-1:0]   pd,
    output logic [2*SW+2:0] num0,
    output logic [2*SW+2:0] den0,
    output logic [2*SW+2:0] num1,
    output logic [2*SW+2:0] den1,
    output logic [1:0]      fin0,
    output logic [1:0]      fin1,
    output logic            use_pi
);

    localparam int DW = SW + 1;
    localparam int NW = 2 * SW + 3;
    localparam int PW = 2 * DW;

    localparam logic [1:0] FIN_ZERO_L = fme_pkg::FIN_ZERO;
    localparam logic [1:0] FIN_ONE_L  = fme_pkg::FIN_ONE;
    localparam logic [1:0] FIN_TERM_L = fme_pkg::FIN_TERM;
    localparam logic [1:0] FIN_INV_L  = fme_pkg::FIN_INV;

    logic signed [SW-1:0] x, a, b, c, d;
    logic signed [DW:0]   x2, ab, cd;
    assign x = x_in;
    assign a = pa;
    assign b = pb;
    assign c = pc;
    assign d = pd;
    assign x2 = {x[SW-1], x, 1'b0};
    assign ab = (DW+1)'(a) + (DW+1)'(b);
    assign cd = (DW+1)'(c) + (DW+1)'(d);

    // Per-curve decision for stage 1: diff, span, quadratic flag, finish.
    typedef struct packed {
        logic [DW-1:0] diff;
        logic [DW-1:0] span;
        logic          quad;
        logic [1:0]    fin;
    } curve_t;

    function automatic curve_t s_dec(logic signed [SW-1:0] xv, logic signed [SW-1:0] lo,
                                     logic signed [SW-1:0] hi, logic signed [DW:0] twox,
                                     logic signed [DW:0] sum);
        curve_t r;
        r.diff = '0;
        r.span = DW'(hi) - DW'(lo);
        r.quad = 1'b1;
        r.fin = FIN_ZERO_L;
        if (lo >= hi) begin
            r.fin = (twox >= sum) ? FIN_ONE_L : FIN_ZERO_L;
        end else if (xv <= lo) begin
            r.fin = FIN_ZERO_L;
        end else if (twox <= sum) begin
            r.diff = DW'(xv) - DW'(lo);
            r.fin = FIN_TERM_L;
        end else if (xv >= hi) begin
            r.fin = FIN_ONE_L;
        end else begin
            r.diff = DW'(hi) - DW'(xv);
            r.fin = FIN_INV_L;
        end
        return r;
    endfunction

    function automatic curve_t z_dec(logic signed [SW-1:0] xv, logic signed [SW-1:0] lo,
                                     logic signed [SW-1:0] hi, logic signed [DW:0] twox,
                                     logic signed [DW:0] sum);
        curve_t r;
        r.diff = '0;
        r.span = DW'(hi) - DW'(lo);
        r.quad = 1'b1;
        r.fin = FIN_ZERO_L;
        if (lo >= hi) begin
            r.fin = (twox <= sum) ? FIN_ONE_L : FIN_ZERO_L;
        end else if (xv <= lo) begin
            r.fin = FIN_ONE_L;
        end else if (xv >= hi) begin
            r.fin = FIN_ZERO_L;
        end else if (twox <= sum) begin
            r.diff = DW'(xv) - DW'(lo);
            r.fin = FIN_INV_L;
        end else begin
            r.diff = DW'(hi) - DW'(xv);
            r.fin = FIN_TERM_L;
        end
        return r;
    endfunction

    curve_t c0_next, c1_next, c0_reg, c1_reg;
    logic   pi_next, pi_reg;

    always_comb begin
        c0_next = '0;
        c1_next = '0;
        pi_next = 1'b0;
        case (shape)
            fme_pkg::SHAPE_TRI: begin
                if (x > a && x <= b) begin
                    c0_next.diff = DW'(x) - DW'(a);
                    c0_next.span = DW'(b) - DW'(a);
                    c0_next.fin = FIN_TERM_L;
                end else if (x > b && x < c) begin
                    c0_next.diff = DW'(c) - DW'(x);
                    c0_next.span = DW'(c) - DW'(b);
                    c0_next.fin = FIN_TERM_L;
                end
            end
            fme_pkg::SHAPE_TRAP: begin
                if (x > a && x < b) begin
                    c0_next.diff = DW'(x) - DW'(a);
                    c0_next.span = DW'(b) - DW'(a);
                    c0_next.fin = FIN_TERM_L;
                end else if (x > c && x < d) begin
                    c0_next.diff = DW'(d) - DW'(x);
                    c0_next.span = DW'(d) - DW'(c);
                    c0_next.fin = FIN_TERM_L;
                end else if (x >= b && x <= c) begin
                    c0_next.fin = FIN_ONE_L;
                end
            end
            fme_pkg::SHAPE_S: c0_next = s_dec(x, a, b, x2, ab);
            fme_pkg::SHAPE_Z: c0_next = z_dec(x, a, b, x2, ab);
            fme_pkg::SHAPE_PI: begin
                c0_next = s_dec(x, a, b, x2, ab);
                c1_next = z_dec(x, c, d, x2, cd);
                pi_next = 1'b1;
            end
            default: c0_next = '0;
        endcase
    end

    logic [NW-1:0] n0_reg, d0_reg, n1_reg, d1_reg;
    logic [1:0]    f0_reg, f1_reg;
    logic          pi2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            c0_reg <= c0_next;
            c1_reg <= c1_next;
            pi_reg <= pi_next;
            n0_reg <= c0_reg.quad
                      ? NW'({PW'(c0_reg.diff) * PW'(c0_reg.diff), 1'b0})
                      : NW'(c0_reg.diff);
            d0_reg <= c0_reg.quad ? NW'(PW'(c0_reg.span) * PW'(c0_reg.span))
                                  : NW'(c0_reg.span);
            n1_reg <= NW'({PW'(c1_reg.diff) * PW'(c1_reg.diff), 1'b0});
            d1_reg <= NW'(PW'(c1_reg.span) * PW'(c1_reg.span));
            f0_reg <= c0_reg.fin;
            f1_reg <= c1_reg.fin;
            pi2_reg <= pi_reg;
        end
    end

    assign num0 = n0_reg;
    assign den0 = d0_reg;
    assign num1 = n1_reg;
    assign den1 = d1_reg;
    assign fin0 = f0_reg;
    assign fin1 = f1_reg;
    assign use_pi = pi2_reg;

endmodule

// File: tb/sv/tb_fuzzy_membership_eval.sv
// ----------------------------------------------------------------------------
// Fuzzy membership evaluator testbench
// Drives samples under many shape settings, predicts each degree with an
// exact integer model and compares every result beat in order.
// ----------------------------------------------------------------------------
module tb_fuzzy_membership_eval;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW = 16;
    localparam int FB = 15;
    localparam longint ONE = 64'd1 << FB;
    localparam int LATENCY = FB + 6;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [SW-1:0] s_sample = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [FB:0] m_degree;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [SW-1:0] cfg_data = '0;

    logic [2:0] shape;
    logic signed [SW-1:0] pa, pb, pc, pd;
    logic [FB:0] degree_queue[$];
    int errors = 0;
    int hold_cycles = 0;
    bit hold_request = 1'b0;
    bit hold_taken = 1'b0;
    bit stall_enable = 1'b1;

    fuzzy_membership_eval dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #50ms;
        $display("tb_fuzzy_membership_eval: done, errors");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // floor(num * 2^FB / den), saturated at one; zero divisor gives zero.
    function automatic longint frac_ratio(logic [127:0] num, logic [127:0] den);
        logic [127:0] q;
        if (den == 0) return 0;
        if (num >= den) return ONE;
        q = (num << FB) / den;
        return longint'(q);
    endfunction

    function automatic longint quad_term(longint diff, longint span);
        return frac_ratio(128'(2 * diff * diff), 128'(span * span));
    endfunction

    function automatic longint s_part(longint x, longint a, longint b);
        if (a >= b) return (2 * x >= a + b) ? ONE : 0;
        if (x <= a) return 0;
        if (2 * x <= a + b) return quad_term(x - a, b - a);
        if (x >= b) return ONE;
        return ONE - quad_term(b - x, b - a);
    endfunction

    function automatic longint z_part(longint x, longint a, longint b);
        if (a >= b) return (2 * x <= a + b) ? ONE : 0;
        if (x <= a) return ONE;
        if (x >= b) return 0;
        if (2 * x <= a + b) return ONE - quad_term(x - a, b - a);
        return quad_term(b - x, b - a);
    endfunction

    function automatic logic [FB:0] membership(logic signed [SW-1:0] xs);
        longint x, a, b, c, d, deg;
        x = xs; a = pa; b = pb; c = pc; d = pd;
        deg = 0;
        case (shape)
            fme_pkg::SHAPE_TRI: begin
                if (x > a && x <= b) deg = frac_ratio(128'(x - a), 128'(b - a));
                else if (x > b && x < c) deg = frac_ratio(128'(c - x), 128'(c - b));
            end
            fme_pkg::SHAPE_TRAP: begin
                if (x > a && x < b) deg = frac_ratio(128'(x - a), 128'(b - a));
                else if (x > c && x < d) deg = frac_ratio(128'(d - x), 128'(d - c));
                else if (x >= b && x <= c) deg = ONE;
            end
            fme_pkg::SHAPE_S: deg = s_part(x, a, b);
            fme_pkg::SHAPE_Z: deg = z_part(x, a, b);
            fme_pkg::SHAPE_PI: deg = (s_part(x, a, b) * z_part(x, c, d)) >> FB;
            default: deg = 0;
        endcase
        if (deg > ONE) deg = ONE;
        return deg[FB:0];
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [SW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            fme_pkg::REG_SHAPE: shape = data[2:0];
            fme_pkg::REG_POINT_A: pa = data;
            fme_pkg::REG_POINT_B: pb = data;
            fme_pkg::REG_POINT_C: pc = data;
            default: pd = data;
        endcase
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (degree_queue.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic set_shape(logic [2:0] s, logic [SW-1:0] a, logic [SW-1:0] b,
                             logic [SW-1:0] c, logic [SW-1:0] d);
        drain();
        write_reg(fme_pkg::REG_SHAPE, {13'd0, s});
        write_reg(fme_pkg::REG_POINT_A, a);
        write_reg(fme_pkg::REG_POINT_B, b);
        write_reg(fme_pkg::REG_POINT_C, c);
        write_reg(fme_pkg::REG_POINT_D, d);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(logic [SW-1:0] x, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sample <= x;
        do @(posedge aclk); while (!s_ready);
        degree_queue.push_back(membership(x));
    endtask

    function automatic logic [SW-1:0] near_point();
        logic signed [SW-1:0] p;
        case ($urandom_range(0, 3))
            0: p = pa;
            1: p = pb;
            2: p = pc;
            default: p = pd;
        endcase
        return p + SW'($signed($urandom_range(0, 64)) - 32);
    endfunction

    function automatic logic [SW-1:0] rand_sample();
        if ($urandom_range(0, 2) == 0) return SW'($urandom());
        return near_point();
    endfunction

    task automatic test_reset_defaults();
        shape = fme_pkg::SHAPE_TRI; pa = 0; pb = 0; pc = 0; pd = 0;
        send_sample(16'h0000, 0);
        send_sample(16'h8000, 0);
        send_sample(16'h7FFF, 0);
    endtask

    task automatic test_directed_shapes();
        set_shape(fme_pkg::SHAPE_TRI, 16'hFF00, 16'h0000, 16'h0100, 16'h0);
        send_sample(16'hFF00, 0); send_sample(16'hFF80, 0);
        send_sample(16'h0000, 0); send_sample(16'h0080, 0);
        set_shape(fme_pkg::SHAPE_TRAP, 16'h8000, 16'hC000, 16'h4000, 16'h7FFF);
        send_sample(16'h8001, 0); send_sample(16'h0000, 0);
        send_sample(16'h7FFE, 0); send_sample(16'h4000, 0);
        set_shape(fme_pkg::SHAPE_S, 16'h0000, 16'h0200, 16'h0, 16'h0);
        send_sample(16'h0100, 0); send_sample(16'h0101, 0); send_sample(16'h01FF, 0);
        // Degenerate S and Z collapse to a step at the midpoint.
        set_shape(fme_pkg::SHAPE_S, 16'h0201, 16'h0100, 16'h0, 16'h0);
        send_sample(16'h0180, 0); send_sample(16'h0181, 0); send_sample(16'h017F, 0);
        set_shape(fme_pkg::SHAPE_Z, 16'h0100, 16'h0100, 16'h0, 16'h0);
        send_sample(16'h0100, 0); send_sample(16'h0101, 0);
        set_shape(fme_pkg::SHAPE_PI, 16'h8000, 16'h0000, 16'h0000, 16'h7FFF);
        send_sample(16'hC000, 0); send_sample(16'h0000, 0); send_sample(16'h4000, 0);
        // Unused shape codes give zero.
        set_shape(3'd7, 16'h0, 16'h100, 16'h200, 16'h300);
        send_sample(16'h0100, 0);
        set_shape(3'd5, 16'h0, 16'h100, 16'h200, 16'h300);
        send_sample(16'h0180, 0);
    endtask

    task automatic test_random_phases();
        logic [SW-1:0] p[4];
        logic [SW-1:0] t;
        for (int ph = 0; ph < 34; ph++) begin
            for (int k = 0; k < 4; k++) begin
                p[k] = (ph % 5 == 4) ? SW'($urandom())
                                     : SW'($signed($urandom_range(0, 4096)) - 2048);
            end
            if ($urandom_range(0, 3) != 0) begin
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3 - i; j++) begin
                        if ($signed(p[j]) > $signed(p[j + 1])) begin
                            t = p[j]; p[j] = p[j + 1]; p[j + 1] = t;
                        end
                    end
                end
            end
            set_shape((ph % 11 == 10) ? 3'($urandom_range(5, 7)) : 3'(ph % 5),
                      p[0], p[1], p[2], p[3]);
            for (int n = 0; n < 48; n++) send_sample(rand_sample(), ph % 4 != 3);
        end
    endtask

    task automatic test_back_pressure();
        set_shape(fme_pkg::SHAPE_PI, 16'hFE00, 16'hFF00, 16'h0100, 16'h0200);
        hold_request = 1'b1;
        for (int n = 0; n < 60; n++) send_sample(rand_sample(), 0);
        drain();
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (degree_queue.size() == 0) begin
                $error("unexpected degree beat %0d", m_degree);
                errors++;
            end else begin
                if (m_degree !== degree_queue[0]) begin
                    $error("degree: expected %0d, actual %0d", degree_queue[0], m_degree);
                    errors++;
                end
                void'(degree_queue.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else if (hold_request && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_cycles <= 200;
            m_ready <= 1'b0;
        end else if (!stall_enable) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) < 70);
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_directed_shapes();
        test_random_phases();
        test_back_pressure();
        stall_enable = 1'b0;
        drain();
        if (errors == 0 && degree_queue.size() == 0) begin
            $display("tb_fuzzy_membership_eval: done, clean");
        end else begin
            $display("tb_fuzzy_membership_eval: done, errors");
        end
        $finish;
    end
endmodule

// File: sim.f
design/fme_pkg.sv
design/fme_ratio.sv
design/fme_front.sv
design/fuzzy_membership_eval.sv
tb/sv/tb_fuzzy_membership_eval.sv
